### hdl/monotonic_stack_visibility_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the monotonic stack visibility core.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the rising edge and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MONOTONIC_STACK_VISIBILITY_CORE_MACROS_SVH
`define MONOTONIC_STACK_VISIBILITY_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msv assertion failed");

`endif

### hdl/msv_pkg.sv
// ----------------------------------------------------------------------------
// msv_pkg
// Shared sizes, request codes and types of the monotonic stack core.
// ----------------------------------------------------------------------------
package msv_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int HEIGHT_W    = 16;
  localparam int POS_W       = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = HEIGHT_W + POS_W;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Decision of the compare unit for the current top of stack.
  typedef struct packed {
    logic pop;
    logic full;
  } msv_cmp_t;

endpackage

### hdl/msv_ram.sv
// ----------------------------------------------------------------------------
// msv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/msv_cmp.sv
// ----------------------------------------------------------------------------
// msv_cmp
// Shared compare unit: decides whether the top entry is popped by the new
// height and whether the stack is full.
// ----------------------------------------------------------------------------
module msv_cmp
  import msv_pkg::*;
(
  input  logic [CNT_W-1:0]    cnt,
  input  logic [HEIGHT_W-1:0] new_height,
  input  logic [HEIGHT_W-1:0] top_height,
  output msv_cmp_t            result
);

  // An entry that is not greater than the new height can never be seen again.
  assign result.pop  = (cnt != '0) && (new_height >= top_height);
  assign result.full = (cnt == CNT_W'(STACK_DEPTH));

endmodule

### hdl/monotonic_stack_visibility_core.sv
// ----------------------------------------------------------------------------
// monotonic_stack_visibility_core
// Strictly decreasing stack of heights with arrival positions. Pushes pop
// every entry that is not taller, drains emit the survivors and restart.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake           Beat contents
//   -------  ------------------  --------------------------------------------
//   input    in_valid/in_ready   req_type, height
//   output   out_valid/out_ready position, surviving_height, last, overflowed
//
// A push reads the top entry from the stack RAM in the accept cycle; then
// one compare per cycle in the shared compare unit decides pop or store,
// and each pop reads the entry below for the next compare.
// A drain walks the stack from the bottom: each beat passes ST_DRN_RD (output
// register loaded), then ST_DRN_OUT (held until out_ready, next entry read).
// An empty drain finishes in its accept cycle and emits nothing.
// Reset clears the count, position counter and overflow flag at once; the
// stack RAM needs no clearing because only entries below the count are used.
// ----------------------------------------------------------------------------
module monotonic_stack_visibility_core
  import msv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [HEIGHT_W-1:0] height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [POS_W-1:0]    position,
  output logic [HEIGHT_W-1:0] surviving_height,
  output logic                last,
  output logic                overflowed
);

`include "monotonic_stack_visibility_core_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DRN_RD,
    ST_DRN_OUT
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [POS_W-1:0]    next_pos;
  logic                ovf;
  logic [HEIGHT_W-1:0] push_height;
  logic [PTR_W-1:0]    drn_idx;

  // Stack RAM control. Each entry holds {position, height}.
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  msv_cmp_t           cmp;

  logic in_fire;
  logic out_fire;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  msv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The compare unit looks at the entry on the RAM read port; in ST_POP it is the entry read in the previous cycle.
  msv_cmp u_cmp (
    .cnt        (cnt),
    .new_height (push_height),
    .top_height (ram_rdata[HEIGHT_W-1:0]),
    .result     (cmp)
  );

  // Read and write addressing. A push reads the current top as it is
  // accepted; each pop reads the entry below so that the next compare can
  // run in the following cycle. The drain walks the stack from the bottom.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt[PTR_W-1:0];
    ram_wdata = {next_pos, push_height};
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ram_re = 1'b1;
          if (req_type == REQ_PUSH) begin
            ram_raddr = PTR_W'(cnt - CNT_W'(1));
          end else begin
            ram_raddr = '0;
          end
        end
      end
      ST_POP: begin
        if (cmp.pop) begin
          ram_re    = 1'b1;
          ram_raddr = PTR_W'(cnt - CNT_W'(2));
        end else if (!cmp.full) begin
          ram_we = 1'b1;
        end
      end
      ST_DRN_OUT: begin
        if (out_ready && !last) begin
          ram_re    = 1'b1;
          ram_raddr = drn_idx + PTR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      next_pos  <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (req_type == REQ_PUSH) begin
              push_height <= height;
              state       <= ST_POP;
            end else if (cnt == '0) begin
              // Nothing survives; the drain only restarts the position counter and overflow flag.
              next_pos <= '0;
              ovf      <= 1'b0;
            end else begin
              drn_idx <= '0;
              state   <= ST_DRN_RD;
            end
          end
        end
        ST_POP: begin
          if (cmp.pop) begin
            cnt <= cnt - CNT_W'(1);
          end else begin
            if (cmp.full) begin
              // Still full after the pops: the push is dropped.
              ovf <= 1'b1;
            end else begin
              cnt <= cnt + CNT_W'(1);
              if (next_pos != POS_MAX) begin
                next_pos <= next_pos + POS_W'(1);
              end
            end
            state <= ST_IDLE;
          end
        end
        ST_DRN_RD: begin
          position         <= ram_rdata[ENTRY_W-1:HEIGHT_W];
          surviving_height <= ram_rdata[HEIGHT_W-1:0];
          last             <= ((CNT_W'(drn_idx) + CNT_W'(1)) == cnt);
          overflowed       <= ovf;
          out_valid        <= 1'b1;
          state            <= ST_DRN_OUT;
        end
        ST_DRN_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              cnt      <= '0;
              next_pos <= '0;
              ovf      <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              drn_idx <= drn_idx + PTR_W'(1);
              state   <= ST_DRN_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The entry count never goes past the stack depth.
  `MSV_ASSERT_NOW(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(STACK_DEPTH))
  // No new request is taken while a drain beat is pending.
  `MSV_ASSERT_NOW(a_busy_on_out, clk, rst, out_valid, !in_ready)
  // The final drain beat restarts the stack and the position counter.
  `MSV_ASSERT_NEXT(a_drain_clears, clk, rst, out_fire && last, (cnt == '0) && (next_pos == '0))
  // A drain of an empty stack leaves it idle with cleared counters.
  `MSV_ASSERT_NEXT(a_empty_drain, clk, rst, in_fire && (req_type == REQ_DRAIN) && (cnt == '0),
    (state == ST_IDLE) && !ovf && (next_pos == '0))

endmodule
